/* hw/rtl/hbmcg_pkg.sv */
package hbmcg_pkg;

	// Channel count is fixed by the one-bit channel field.
	localparam int CHANNELS = 2;

	localparam int OP_W    = 2;
	localparam int CMD_W   = 16;
	localparam int LEVEL_W = 11;
	localparam int LIMIT_W = 10;
	localparam int STEP_W  = 11;
	localparam int COAST_W = 8;
	localparam int DUTY_W  = 16;
	localparam int MAG_W   = 10;
	localparam int PROD_W  = MAG_W + DUTY_W;
	localparam int ADDR_W  = 3;
	localparam int CFG_W   = 16;

	// Operation codes
	localparam logic [OP_W-1:0] OP_SET    = 2'd0;
	localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
	localparam logic [OP_W-1:0] OP_FAULT  = 2'd2;
	localparam logic [OP_W-1:0] OP_ENABLE = 2'd3;

	// Register indexes
	localparam logic [ADDR_W-1:0] REG_DRIVE_LIMIT = 3'd0;
	localparam logic [ADDR_W-1:0] REG_SLEW_STEP   = 3'd1;
	localparam logic [ADDR_W-1:0] REG_COAST_COUNT = 3'd2;
	localparam logic [ADDR_W-1:0] REG_MAIN_PERIOD = 3'd3;
	localparam logic [ADDR_W-1:0] REG_LEFT_PERIOD = 3'd4;

	// Reset values
	localparam logic [LIMIT_W-1:0] RST_DRIVE_LIMIT = 10'd1000;
	localparam logic [STEP_W-1:0]  RST_SLEW_STEP   = 11'd50;
	localparam logic [COAST_W-1:0] RST_COAST_COUNT = 8'd5;
	localparam logic [DUTY_W-1:0]  RST_MAIN_PERIOD = 16'd2500;
	localparam logic [DUTY_W-1:0]  RST_LEFT_PERIOD = 16'd12500;

	localparam logic [MAG_W-1:0] PERMILLE = 10'd1000;

	// x/1000 = (x>>3)/125; (x>>3) < 2^23, and ceil(2^30/125) is exact over that range
	localparam int              RECIP_SHIFT = 30;
	localparam int              RECIP_W     = 24;
	localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;

	typedef struct packed {
		logic                      ch;
		logic signed [LEVEL_W-1:0] level;
		logic                      en;
		logic                      last;
	} meta_t;

endpackage

/* hw/rtl/hbridge_motor_command_guard_top.sv */
// H-bridge command guard for two motor channels. Requests arrive on the s_ side
// (operation in s_tuser; channel and signed per-mille command in s_tdata) and
// bridge updates leave on the m_ side: channel, applied level, positive and
// negative compare counts and the enable status, with tlast on the final update
// of a request. A set request is clamped to drive_limit, stopped at once on zero,
// held at zero during the coast count after a reversal, and otherwise slewed by at
// most slew_step; it yields one update. Stop-all yields two updates (channel 0,
// then channel 1); fault shutdown yields two while enabled and then blocks sets
// until an enable request. Enable and ignored requests yield nothing. Rate: one
// request per cycle for set and enable while the pipeline is not stalled; stop,
// and fault while enabled, hold s_tready low until their second update has been
// issued into the pipeline. Three register stages: a level/state stage, a duty
// multiply stage and a divide-by-1000 reciprocal multiply stage that is the
// output register. Each stage advances on its own when the one after it has
// room, so requests keep flowing while a finished update waits on m_tready.
// Configuration must be written through cfg_we/cfg_addr/cfg_wdata only while
// no request is in flight; the block itself does not enforce this.
module hbridge_motor_command_guard_top
	import hbmcg_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	// configuration writes
	input  logic              cfg_we,
	input  logic [ADDR_W-1:0] cfg_addr,
	input  logic [CFG_W-1:0]  cfg_wdata,
	// requests
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,   // [0] channel, [16:1] command_level, [23:17] zero
	input  logic [1:0]        s_tuser,   // [1:0] operation
	// bridge updates
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [47:0]       m_tdata,   // [0] out_channel, [11:1] applied_level,
	                                     // [27:12] positive_duty, [43:28] negative_duty,
	                                     // [44] outputs_enabled, [47:45] zero
	output logic              m_tlast
);

	// ---------------- configuration registers ----------------
	logic [LIMIT_W-1:0] drive_limit_q;
	logic [STEP_W-1:0]  slew_step_q;
	logic [COAST_W-1:0] coast_count_q;
	logic [DUTY_W-1:0]  main_period_q;
	logic [DUTY_W-1:0]  left_period_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drive_limit_q <= RST_DRIVE_LIMIT;
			slew_step_q   <= RST_SLEW_STEP;
			coast_count_q <= RST_COAST_COUNT;
			main_period_q <= RST_MAIN_PERIOD;
			left_period_q <= RST_LEFT_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_DRIVE_LIMIT: drive_limit_q <= cfg_wdata[LIMIT_W-1:0];
				REG_SLEW_STEP:   slew_step_q   <= cfg_wdata[STEP_W-1:0];
				REG_COAST_COUNT: coast_count_q <= cfg_wdata[COAST_W-1:0];
				REG_MAIN_PERIOD: main_period_q <= cfg_wdata[DUTY_W-1:0];
				REG_LEFT_PERIOD: left_period_q <= cfg_wdata[DUTY_W-1:0];
				default: ;  // unused indexes are dropped
			endcase
		end
	end

	// ---------------- request fields ----------------
	logic [OP_W-1:0]         op;
	logic                    ch;
	logic signed [CMD_W-1:0] cmd;

	assign op  = s_tuser[OP_W-1:0];
	assign ch  = s_tdata[0];
	assign cmd = s_tdata[CMD_W:1];

	// ---------------- channel state ----------------
	logic signed [LEVEL_W-1:0] applied_q [CHANNELS];
	logic [COAST_W-1:0]        coast_q   [CHANNELS];
	logic                      enabled_q;
	logic                      pend_q;      // second update of stop/fault still owed
	logic                      pend_en_q;   // enable status to report with it

	// pipeline valids and handshake
	logic v_s1, v_s2, v_s3;
	logic adv1, adv2, adv3;
	logic accept;

	assign adv3     = !v_s3 || m_tready;
	assign adv2     = !v_s2 || adv3;
	assign adv1     = !v_s1 || adv2;
	assign s_tready = adv1 && !pend_q;
	assign accept   = s_tvalid && s_tready;

	// ---------------- set: clamp, coast, reversal, slew ----------------
	logic signed [CMD_W:0]     cmd_x, lim_x;
	logic signed [LEVEL_W-1:0] clamped, cur, next_level;
	logic [COAST_W-1:0]        cur_coast, next_coast;
	logic signed [LEVEL_W+1:0] delta, step_x;

	always_comb begin
		cmd_x = {cmd[CMD_W-1], cmd};
		lim_x = {{(CMD_W+1-LIMIT_W){1'b0}}, drive_limit_q};
		if (cmd_x > lim_x)
			clamped = lim_x[LEVEL_W-1:0];
		else if (cmd_x < -lim_x)
			clamped = LEVEL_W'(-lim_x);
		else
			clamped = cmd_x[LEVEL_W-1:0];

		cur       = applied_q[ch];
		cur_coast = coast_q[ch];
		step_x    = {2'b00, slew_step_q};
		delta     = {{2{clamped[LEVEL_W-1]}}, clamped} - {{2{cur[LEVEL_W-1]}}, cur};
		if (delta > step_x)
			delta = step_x;
		else if (delta < -step_x)
			delta = -step_x;

		priority if (clamped == '0) begin
			next_level = '0;
			next_coast = '0;
		end else if (cur_coast != '0) begin
			// coasting after a reversal
			next_level = '0;
			next_coast = cur_coast - COAST_W'(1);
		end else if (cur != '0 && (cur[LEVEL_W-1] != clamped[LEVEL_W-1])) begin
			// reversal: drop to zero and start coasting
			next_level = '0;
			next_coast = coast_count_q;
		end else begin
			next_level = LEVEL_W'({{2{cur[LEVEL_W-1]}}, cur} + delta);
			next_coast = cur_coast;
		end
	end

	// ---------------- state update and stage 1 load ----------------
	meta_t                 load_meta;
	logic                  load_v;
	meta_t                 meta_s1, meta_s2, meta_s3;
	logic [MAG_W-1:0]      mag_s1;
	logic [DUTY_W-1:0]     period_s1;

	always_comb begin
		load_v    = 1'b0;
		load_meta = '{ch: 1'b0, level: '0, en: enabled_q, last: 1'b0};
		if (pend_q) begin
			load_v    = 1'b1;
			load_meta = '{ch: 1'b1, level: '0, en: pend_en_q, last: 1'b1};
		end else if (accept) begin
			unique case (op)
				OP_SET: begin
					load_v    = enabled_q;
					load_meta = '{ch: ch, level: next_level, en: 1'b1, last: 1'b1};
				end
				OP_STOP: begin
					load_v    = 1'b1;
					load_meta = '{ch: 1'b0, level: '0, en: enabled_q, last: 1'b0};
				end
				OP_FAULT: begin
					load_v    = enabled_q;
					load_meta = '{ch: 1'b0, level: '0, en: 1'b0, last: 1'b0};
				end
				OP_ENABLE: load_v = 1'b0;
			endcase
		end
	end

	// magnitude capped at 1000, period chosen by direction and channel
	logic [LEVEL_W-1:0] abs_level;
	logic [MAG_W-1:0]   load_mag;
	logic [DUTY_W-1:0]  load_period;

	always_comb begin
		abs_level = load_meta.level[LEVEL_W-1] ? LEVEL_W'(-load_meta.level)
		                                       : load_meta.level;
		load_mag  = (abs_level > {1'b0, PERMILLE}) ? PERMILLE : abs_level[MAG_W-1:0];
		if (!load_meta.level[LEVEL_W-1] && !load_meta.ch)
			load_period = left_period_q;
		else
			load_period = main_period_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				applied_q[i] <= '0;
				coast_q[i]   <= '0;
			end
			enabled_q <= 1'b0;
			pend_q    <= 1'b0;
			pend_en_q <= 1'b0;
		end else begin
			if (pend_q && adv1)
				pend_q <= 1'b0;
			if (accept) begin
				unique case (op)
					OP_SET: begin
						if (enabled_q) begin
							applied_q[ch] <= next_level;
							coast_q[ch]   <= next_coast;
						end
					end
					OP_STOP: begin
						for (int i = 0; i < CHANNELS; i++) begin
							applied_q[i] <= '0;
							coast_q[i]   <= '0;
						end
						pend_q    <= 1'b1;
						pend_en_q <= enabled_q;
					end
					OP_FAULT: begin
						if (enabled_q) begin
							for (int i = 0; i < CHANNELS; i++) begin
								applied_q[i] <= '0;
								coast_q[i]   <= '0;
							end
							enabled_q <= 1'b0;
							pend_q    <= 1'b1;
							pend_en_q <= 1'b0;
						end
					end
					OP_ENABLE: enabled_q <= 1'b1;
				endcase
			end
		end
	end

	// ---------------- pipeline ----------------
	logic [PROD_W-1:0]                  prod_s2;
	logic [PROD_W-4:0]                  prod_div8;
	logic [PROD_W-3+RECIP_W-1:0]        quot_full;
	logic [DUTY_W-1:0]                  pos_s3, neg_s3;

	assign prod_div8 = prod_s2[PROD_W-1:3];
	assign quot_full = {{RECIP_W{1'b0}}, prod_div8} * {{(PROD_W-3){1'b0}}, RECIP_125};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= load_v;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			meta_s1   <= load_meta;
			mag_s1    <= load_mag;
			period_s1 <= load_period;
		end
		if (adv2) begin
			meta_s2 <= meta_s1;
			prod_s2 <= {{DUTY_W{1'b0}}, mag_s1} * {{MAG_W{1'b0}}, period_s1};
		end
		if (adv3) begin
			meta_s3 <= meta_s2;
			// zero level gives zero product, so both pins read zero
			if (meta_s2.level[LEVEL_W-1]) begin
				pos_s3 <= '0;
				neg_s3 <= quot_full[RECIP_SHIFT +: DUTY_W];
			end else begin
				pos_s3 <= quot_full[RECIP_SHIFT +: DUTY_W];
				neg_s3 <= '0;
			end
		end
	end

	// ---------------- outputs ----------------
	assign m_tvalid = v_s3;
	assign m_tlast  = meta_s3.last;
	assign m_tdata  = {3'b000, meta_s3.en, neg_s3, pos_s3, meta_s3.level, meta_s3.ch};

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

// Testbench for the H-bridge command guard.
// Requests go in on s_ with random sender gaps. Bridge updates come out on m_
// with random receiver stalls. An in-bench predictor tracks level, coast counter
// and enable state per channel and queues the updates each request should cause.
// A single monitor pops that queue and compares every field of every update.
module tb_top;
	import hbmcg_pkg::*;

	localparam int FULL_SCALE = 1000;   // per-mille full scale, duty caps here
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the fill test

	// One bridge update as it appears on m_tdata / m_tlast
	typedef struct packed {
		logic                      ch;
		logic signed [LEVEL_W-1:0] level;
		logic [DUTY_W-1:0]         pos;
		logic [DUTY_W-1:0]         neg;
		logic                      en;
		logic                      last;
	} bridge_update_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               cfg_we    = 1'b0;
	logic [ADDR_W-1:0]  cfg_addr  = '0;
	logic [CFG_W-1:0]   cfg_wdata = '0;
	logic               s_tvalid  = 1'b0;
	logic               s_tready;
	logic [23:0]        s_tdata   = '0;   // [0] channel, [16:1] command_level, [23:17] zero
	logic [1:0]         s_tuser   = '0;   // [1:0] operation
	logic               m_tvalid;
	logic               m_tready  = 1'b0;
	logic [47:0]        m_tdata;          // [0] ch, [11:1] level, [27:12] pos duty,
	                                      // [43:28] neg duty, [44] enabled, [47:45] zero
	logic               m_tlast;

	// Predictor state: applied level and coast counter per channel, enable flag
	int lvl_now[CHANNELS];
	int coast_left[CHANNELS];
	bit drive_on;

	// Predictor copy of the configuration registers
	int lim_reg;
	int step_reg;
	int coast_reg;
	int main_per;
	int left_per;

	// Direction the random commands currently lean toward, per channel
	bit aim_neg[CHANNELS];

	bridge_update_t update_q[$];   // updates still owed by the block, oldest first
	int mismatch_cnt = 0;

	// Idling knobs, in percent of cycles
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;

	// Long receiver hold-off, requested by a test and counted by the receiver
	bit hold_pending = 1'b0;
	int hold_left    = 0;

	hbridge_motor_command_guard_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------- predictor

	// Compare count: |level| capped at full scale, times period, over full scale
	function automatic logic [DUTY_W-1:0] compare_count(input int level, input int period);
		int mag;
		mag = (level < 0) ? -level : level;
		if (mag > FULL_SCALE) mag = FULL_SCALE;
		return DUTY_W'((mag * period) / FULL_SCALE);
	endfunction

	// Queue the update for one channel from its current level.
	// Channel 0 drives its positive side off its own period.
	function automatic void queue_update(input int c, input bit last);
		bridge_update_t u;
		u.ch    = c[0];
		u.level = LEVEL_W'(lvl_now[c]);
		u.pos   = '0;
		u.neg   = '0;
		if (lvl_now[c] > 0) begin
			u.pos = compare_count(lvl_now[c], (c == 0) ? left_per : main_per);
		end else if (lvl_now[c] < 0) begin
			u.neg = compare_count(lvl_now[c], main_per);
		end
		u.en   = drive_on;
		u.last = last;
		update_q.push_back(u);
	endfunction

	// Stop or fault: every channel to zero, coast cleared, one update each
	function automatic void clear_channels();
		for (int c = 0; c < CHANNELS; c++) begin
			lvl_now[c]    = 0;
			coast_left[c] = 0;
		end
		for (int c = 0; c < CHANNELS; c++) queue_update(c, c == CHANNELS - 1);
	endfunction

	// Advance the predictor by one accepted request
	function automatic void predict_request(input logic [OP_W-1:0] op, input logic ch,
			input logic signed [CMD_W-1:0] cmd);
		int c;
		int want;
		int delta;
		c = ch;
		case (op)
			OP_STOP: clear_channels();
			OP_FAULT: begin
				// fault only acts while enabled
				if (drive_on) begin
					drive_on = 1'b0;
					clear_channels();
				end
			end
			OP_ENABLE: drive_on = 1'b1;
			default: begin
				if (drive_on) begin
					want = cmd;
					if (want > lim_reg) want = lim_reg;
					if (want < -lim_reg) want = -lim_reg;
					if (want == 0) begin
						// immediate stop, coast dropped
						lvl_now[c]    = 0;
						coast_left[c] = 0;
					end else if (coast_left[c] != 0) begin
						coast_left[c]--;
						lvl_now[c] = 0;
					end else if (lvl_now[c] != 0 && ((lvl_now[c] < 0) != (want < 0))) begin
						// reversal: force zero, start coasting
						lvl_now[c]    = 0;
						coast_left[c] = coast_reg;
					end else begin
						delta = want - lvl_now[c];
						if (delta > step_reg) delta = step_reg;
						else if (delta < -step_reg) delta = -step_reg;
						lvl_now[c] += delta;
					end
					queue_update(c, 1'b1);
				end
			end
		endcase
	endfunction

	// ------------------------------------------------------------------ checking

	function automatic void flag_field(input string name, input logic [DUTY_W-1:0] expv,
			input logic [DUTY_W-1:0] actv);
		if (actv !== expv) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expv, actv);
			mismatch_cnt++;
		end
	endfunction

	function automatic void check_update(input bridge_update_t want, input bridge_update_t got);
		flag_field("out_channel", DUTY_W'(want.ch), DUTY_W'(got.ch));
		flag_field("applied_level", DUTY_W'(unsigned'(want.level)), DUTY_W'(unsigned'(got.level)));
		flag_field("positive_duty", want.pos, got.pos);
		flag_field("negative_duty", want.neg, got.neg);
		flag_field("outputs_enabled", DUTY_W'(want.en), DUTY_W'(got.en));
		flag_field("last", DUTY_W'(want.last), DUTY_W'(got.last));
	endfunction

	// Receiver: checks each accepted update, then decides tready for the next cycle.
	// Values are sampled before this edge's updates land, so ordering is safe.
	always @(posedge clk) begin
		bridge_update_t got;
		if (m_tvalid && m_tready) begin
			got.ch    = m_tdata[0];
			got.level = m_tdata[11:1];
			got.pos   = m_tdata[27:12];
			got.neg   = m_tdata[43:28];
			got.en    = m_tdata[44];
			got.last  = m_tlast;
			if (update_q.size() == 0) begin
				$display("%0t: unexpected update, expected none, actual %h last %b",
					$time, m_tdata, m_tlast);
				mismatch_cnt++;
			end else begin
				check_update(update_q.pop_front(), got);
			end
		end
		if (hold_pending) begin
			hold_pending = 1'b0;
			hold_left    = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// ------------------------------------------------------------------ stimulus

	// Send one request. tvalid is only lowered when a gap is taken, so back-to-back
	// requests keep it high without a second assignment in the same step.
	task automatic send_request(input logic [OP_W-1:0] op, input logic ch,
			input logic signed [CMD_W-1:0] cmd);
		if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {7'd0, cmd, ch};
		do @(posedge clk); while (!s_tready);
		predict_request(op, ch, cmd);
	endtask

	// Drop tvalid and let the pipeline drain before touching configuration.
	// Enable and ignored requests leave no update, so keep waiting after the queue empties.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (update_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic program_bridge(input int limit, input int step, input int coast,
			input int mainp, input int leftp);
		logic [ADDR_W-1:0] idx[5];
		int vals[5];
		idx  = '{REG_DRIVE_LIMIT, REG_SLEW_STEP, REG_COAST_COUNT, REG_MAIN_PERIOD,
			REG_LEFT_PERIOD};
		vals = '{limit, step, coast, mainp, leftp};
		wait_idle();
		for (int i = 0; i < 5; i++) begin
			cfg_we    <= 1'b1;
			cfg_addr  <= idx[i];
			cfg_wdata <= CFG_W'(vals[i]);
			@(posedge clk);
		end
		cfg_we    <= 1'b0;
		lim_reg   = limit & ((1 << LIMIT_W) - 1);
		step_reg  = step & ((1 << STEP_W) - 1);
		coast_reg = coast & ((1 << COAST_W) - 1);
		main_per  = mainp & ((1 << DUTY_W) - 1);
		left_per  = leftp & ((1 << DUTY_W) - 1);
	endtask

	// Command for a set: mostly same-direction ramps so slewing and coasting get
	// exercised, with zeros, raw 16-bit noise and clamp extremes mixed in.
	function automatic logic signed [CMD_W-1:0] pick_command(input int c);
		int mag;
		if ($urandom_range(9) == 0) aim_neg[c] = ~aim_neg[c];
		case ($urandom_range(9))
			0: return CMD_W'($urandom);
			1: return '0;
			2: begin
				case ($urandom_range(5))
					0: return 16'sh7FFF;
					1: return 16'sh8000;
					2: return CMD_W'(lim_reg);
					3: return CMD_W'(-lim_reg);
					4: return 16'sd1;
					default: return -16'sd1;
				endcase
			end
			default: begin
				mag = $urandom_range(lim_reg + 30, 1);
				return aim_neg[c] ? CMD_W'(-mag) : CMD_W'(mag);
			end
		endcase
	endfunction

	// Random mix; sets that the block would ignore are not counted
	task automatic random_requests(input int count);
		int done_cnt;
		int roll;
		logic [OP_W-1:0] op;
		logic ch;
		logic signed [CMD_W-1:0] cmd;
		done_cnt = 0;
		while (done_cnt < count) begin
			roll = $urandom_range(99);
			ch   = 1'($urandom_range(1));
			cmd  = CMD_W'($urandom);
			if (!drive_on && roll < 70) op = OP_ENABLE;
			else if (roll < 4) op = OP_STOP;
			else if (roll < 7) op = OP_FAULT;
			else if (roll < 10) op = OP_ENABLE;
			else begin
				op  = OP_SET;
				cmd = pick_command(ch);
			end
			if (op != OP_SET || drive_on) done_cnt++;
			send_request(op, ch, cmd);
		end
	endtask

	// Run random requests across the four idling phases
	task automatic run_phases(input int count);
		int tx_tab[4];
		int rx_tab[4];
		tx_tab = '{0, 59, 0, 14};
		rx_tab = '{0, 0, 59, 14};
		for (int p = 0; p < 4; p++) begin
			tx_idle_pct  = tx_tab[p];
			rx_stall_pct = rx_tab[p];
			random_requests(count / 4);
		end
	endtask

	// --------------------------------------------------------------------- tests

	// Reset configuration: disabled behavior, clamping, slew, reversal and coast,
	// zero stop, stop-all, fault and re-enable
	task automatic test_directed();
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_request(OP_SET, 1'b0, 500);        // disabled: dropped
		send_request(OP_FAULT, 1'b0, 0);        // fault while disabled: dropped
		send_request(OP_STOP, 1'b1, -1);        // stop works while disabled
		send_request(OP_ENABLE, 1'b0, 0);
		send_request(OP_SET, 1'b0, 32767);      // clamp high, first slew step
		send_request(OP_SET, 1'b0, 1000);
		send_request(OP_SET, 1'b1, -32768);     // clamp low
		send_request(OP_SET, 1'b1, -1);         // smaller than one step
		send_request(OP_SET, 1'b0, -1000);      // reversal starts coast
		send_request(OP_SET, 1'b0, -1000);      // held at zero
		send_request(OP_SET, 1'b0, 0);          // zero stop clears coast
		send_request(OP_SET, 1'b0, -1000);
		send_request(OP_SET, 1'b1, 1);          // reversal on channel 1
		send_request(OP_STOP, 1'b0, 0);
		send_request(OP_SET, 1'b1, 700);        // coast was cleared by stop
		send_request(OP_FAULT, 1'b1, 123);
		send_request(OP_SET, 1'b1, 700);        // blocked after fault
		send_request(OP_FAULT, 1'b0, 0);        // already disabled: dropped
		send_request(OP_ENABLE, 1'b1, -5);
		send_request(OP_ENABLE, 1'b0, 0);
		send_request(OP_SET, 1'b0, 1000);
		send_request(OP_SET, 1'b1, -1000);
	endtask

	task automatic test_default_config();
		run_phases(300);
	endtask

	// Limit zero and then three, unit step, no coast, one-count periods
	task automatic test_narrow_config();
		program_bridge(0, 1, 0, 1, 1);
		run_phases(200);
		program_bridge(3, 1, 0, 1, 1);
		run_phases(100);
	endtask

	// Limit above full scale, largest step, longest coast, full periods
	task automatic test_wide_config();
		program_bridge((1 << LIMIT_W) - 1, (1 << STEP_W) - 1, (1 << COAST_W) - 1, 65535, 65535);
		run_phases(400);
	endtask

	// Slew of zero freezes the level; zero periods give zero duty
	task automatic test_zero_slew_and_period();
		program_bridge(500, 0, 1, 0, 0);
		run_phases(200);
	endtask

	task automatic test_random_configs();
		for (int k = 0; k < 4; k++) begin
			program_bridge($urandom_range(1000), $urandom_range(2000, 1), $urandom_range(20),
				$urandom_range(65535, 1), $urandom_range(65535, 1));
			run_phases(140);
		end
	endtask

	// Receiver holds off for a long stretch while requests keep coming,
	// so the pipeline fills and s_tready drops
	task automatic test_backpressure();
		program_bridge(RST_DRIVE_LIMIT, 200, 2, RST_MAIN_PERIOD, RST_LEFT_PERIOD);
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		send_request(OP_ENABLE, 1'b0, 0);
		hold_pending = 1'b1;
		random_requests(80);
		run_phases(200);
	endtask

	initial begin
		for (int c = 0; c < CHANNELS; c++) begin
			lvl_now[c]    = 0;
			coast_left[c] = 0;
			aim_neg[c]    = 1'b0;
		end
		drive_on  = 1'b0;
		lim_reg   = RST_DRIVE_LIMIT;
		step_reg  = RST_SLEW_STEP;
		coast_reg = RST_COAST_COUNT;
		main_per  = RST_MAIN_PERIOD;
		left_per  = RST_LEFT_PERIOD;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_default_config();
		test_narrow_config();
		test_wide_config();
		test_zero_slew_and_period();
		test_random_configs();
		test_backpressure();

		// drain: no more stalls, wait out everything owed plus pipeline latency
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		s_tvalid <= 1'b0;
		while (update_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	// Watchdog, well beyond the slowest legal run
	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule
